// ----- sv/rcl_pkg.sv -----
// Shared types and constants for the region continuity ledger.
`default_nettype none

package rcl_pkg;

    // Stream widths.
    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 496;

    // Configuration port.
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 64;
    localparam int CFG_IDX_LO = 3;

    localparam logic [1:0] REG_ABS_TOL = 2'd0;
    localparam logic [1:0] REG_REL_TOL = 2'd1;
    localparam logic [1:0] REG_STEP    = 2'd2;

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = 1;

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic [48:0] change;
        logic [48:0] rate_sum;
        logic        last;
    } rcl_item_t;

    // Configuration values seen by the back end.
    typedef struct packed {
        logic [47:0] abs_tolerance;
        logic [15:0] rel_tolerance;
        logic [31:0] step_duration;
    } rcl_cfg_t;

endpackage

`default_nettype wire

// ----- sv/rcl_front.sv -----
// Input acceptance, item classification and the short queue to the back end.
`default_nettype none

module rcl_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // prev_volume, cur_volume, prev_rate, cur_rate
    input  wire logic [rcl_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tlast,
    output logic                                q_valid,
    output rcl_pkg::rcl_item_t                  q_item,
    input  wire logic                           q_pop
);

    rcl_pkg::rcl_item_t                entries_reg [rcl_pkg::FIFO_DEPTH];
    logic [rcl_pkg::PTR_W-1:0]         wr_ptr_reg;
    logic [rcl_pkg::PTR_W-1:0]         wr_ptr_next;
    logic [rcl_pkg::PTR_W-1:0]         rd_ptr_reg;
    logic [rcl_pkg::PTR_W-1:0]         rd_ptr_next;
    logic [rcl_pkg::PTR_W:0]           count_reg;
    logic [rcl_pkg::PTR_W:0]           count_next;
    logic                              push;
    rcl_pkg::rcl_item_t                new_item;
    logic [47:0]                       prev_volume;
    logic [47:0]                       cur_volume;
    logic [47:0]                       prev_rate;
    logic [47:0]                       cur_rate;

    assign prev_volume = s_tdata[47:0];
    assign cur_volume  = s_tdata[95:48];
    assign prev_rate   = s_tdata[143:96];
    assign cur_rate    = s_tdata[191:144];

    always_comb
    begin
        new_item.change   = {1'b0, cur_volume} - {1'b0, prev_volume};
        new_item.rate_sum = {prev_rate[47], prev_rate} + {cur_rate[47], cur_rate};
        new_item.last     = s_tlast;
    end

    assign s_tready = (count_reg != (rcl_pkg::PTR_W+1)'(rcl_pkg::FIFO_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == rcl_pkg::PTR_W'(rcl_pkg::FIFO_DEPTH-1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rcl_pkg::PTR_W'(rcl_pkg::FIFO_DEPTH-1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= new_item;
        end
    end

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count did not follow a push");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("item popped from an empty queue");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (rcl_pkg::PTR_W+1)'(rcl_pkg::FIFO_DEPTH))
        else $error("queue fill count exceeds depth");

endmodule

`default_nettype wire

// ----- sv/rcl_back.sv -----
// Arithmetic sequencer, running totals and output register of the ledger.
`default_nettype none

module rcl_back #(
    parameter int MAX_REGIONS = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_valid,
    input  wire rcl_pkg::rcl_item_t              q_item,
    output logic                                 q_pop,
    input  wire rcl_pkg::rcl_cfg_t               cfg,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // region_number, volume_change, integrated_volume, residual, tolerance,
    // within_tolerance, failed_count, max_abs_residual, total_volume_change,
    // total_integrated, total_residual, zero fill
    output logic [rcl_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast
);

    localparam int CNT_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    localparam logic [55:0] POS55   = 56'h7F_FFFF_FFFF_FFFF;
    localparam logic [55:0] NEG55   = 56'h80_0000_0000_0000;
    localparam logic [63:0] POS55_P = 64'h0080_0000_0000_0000;
    localparam logic [12:0] FAIL_MAX = 13'h1FFF;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MAG  = 11'b000_0000_0010,
        S_MUL  = 11'b000_0000_0100,
        S_RND  = 11'b000_0000_1000,
        S_INT  = 11'b000_0001_0000,
        S_SAT  = 11'b000_0010_0000,
        S_RES  = 11'b000_0100_0000,
        S_REF  = 11'b000_1000_0000,
        S_TOL  = 11'b001_0000_0000,
        S_CMP  = 11'b010_0000_0000,
        S_UPD  = 11'b100_0000_0000
    } state_t;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            sat_add64 = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            sat_add64 = s[63:0];
        end
    endfunction

    state_t                 state_reg;
    state_t                 state_next;
    rcl_pkg::rcl_item_t     item_reg;
    logic [48:0]            am_reg;
    logic [48:0]            ac_reg;
    logic [63:0]            plo_reg;
    logic [48:0]            phi_reg;
    logic [64:0]            lornd_reg;
    logic [63:0]            im_reg;
    logic [55:0]            integ_reg;
    logic [56:0]            sum_reg;
    logic [55:0]            ai_reg;
    logic [55:0]            resid_reg;
    logic [55:0]            ref_reg;
    logic [55:0]            aresid_reg;
    logic [55:0]            p1_reg;
    logic [15:0]            p2_reg;
    logic [55:0]            tol_reg;

    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [12:0]            fail_reg;
    logic [12:0]            fail_next;
    logic [55:0]            peak_reg;
    logic [55:0]            peak_next;
    logic [63:0]            sum_chg_reg;
    logic [63:0]            sum_chg_next;
    logic [63:0]            sum_int_reg;
    logic [63:0]            sum_int_next;
    logic [63:0]            sum_res_reg;
    logic [63:0]            sum_res_next;

    logic                   m_tvalid_reg;
    logic [rcl_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tlast_reg;

    logic [63:0]            mul_lo;
    logic [48:0]            mul_hi;
    logic [55:0]            mul_p1;
    logic [31:0]            mul_p2;
    logic [55:0]            scaled;
    logic                   out_free;
    logic                   load;
    logic                   in_tol;
    logic [12:0]            fail_upd;
    logic [55:0]            peak_upd;
    logic [63:0]            sum_chg_upd;
    logic [63:0]            sum_int_upd;
    logic [63:0]            sum_res_upd;
    logic [CNT_W+11:0]      cnt_ext;

    assign mul_lo = am_reg[31:0] * cfg.step_duration;
    assign mul_hi = am_reg[48:32] * cfg.step_duration;
    assign mul_p1 = ref_reg[55:16] * cfg.rel_tolerance;
    assign mul_p2 = ref_reg[15:0] * cfg.rel_tolerance;
    assign scaled = p1_reg + {40'b0, p2_reg};

    assign out_free = !m_tvalid_reg || m_tready;
    assign load     = (state_reg == S_UPD) && out_free;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    assign in_tol      = (aresid_reg <= tol_reg);
    assign fail_upd    = (!in_tol && fail_reg != FAIL_MAX) ? fail_reg + 1'b1 : fail_reg;
    assign peak_upd    = (aresid_reg > peak_reg) ? aresid_reg : peak_reg;
    assign sum_chg_upd = sat_add64(sum_chg_reg, {{15{item_reg.change[48]}}, item_reg.change});
    assign sum_int_upd = sat_add64(sum_int_reg, {{8{integ_reg[55]}}, integ_reg});
    assign sum_res_upd = sat_add64(sum_res_reg, {{8{resid_reg[55]}}, resid_reg});
    assign cnt_ext     = {12'b0, cnt_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = S_MAG;
            S_MAG:  state_next = S_MUL;
            S_MUL:  state_next = S_RND;
            S_RND:  state_next = S_INT;
            S_INT:  state_next = S_SAT;
            S_SAT:  state_next = S_RES;
            S_RES:  state_next = S_REF;
            S_REF:  state_next = S_TOL;
            S_TOL:  state_next = S_CMP;
            S_CMP:  state_next = S_UPD;
            S_UPD:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        fail_next    = fail_reg;
        peak_next    = peak_reg;
        sum_chg_next = sum_chg_reg;
        sum_int_next = sum_int_reg;
        sum_res_next = sum_res_reg;
        if (load)
        begin
            if (item_reg.last)
            begin
                cnt_next     = '0;
                fail_next    = '0;
                peak_next    = '0;
                sum_chg_next = '0;
                sum_int_next = '0;
                sum_res_next = '0;
            end
            else
            begin
                cnt_next     = (cnt_reg == CNT_W'(MAX_REGIONS-1)) ? '0 : cnt_reg + 1'b1;
                fail_next    = fail_upd;
                peak_next    = peak_upd;
                sum_chg_next = sum_chg_upd;
                sum_int_next = sum_int_upd;
                sum_res_next = sum_res_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            fail_reg     <= '0;
            peak_reg     <= '0;
            sum_chg_reg  <= '0;
            sum_int_reg  <= '0;
            sum_res_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            fail_reg     <= fail_next;
            peak_reg     <= peak_next;
            sum_chg_reg  <= sum_chg_next;
            sum_int_reg  <= sum_int_next;
            sum_res_reg  <= sum_res_next;
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_reg <= q_item;
                end
            end
            S_MAG:
            begin
                am_reg <= item_reg.rate_sum[48] ? 49'd0 - item_reg.rate_sum : item_reg.rate_sum;
                ac_reg <= item_reg.change[48] ? 49'd0 - item_reg.change : item_reg.change;
            end
            S_MUL:
            begin
                plo_reg <= mul_lo;
                phi_reg <= mul_hi;
            end
            S_RND:
            begin
                lornd_reg <= {1'b0, plo_reg} + 65'h1_0000;
            end
            S_INT:
            begin
                im_reg <= {phi_reg, 15'b0} + {16'b0, lornd_reg[64:17]};
            end
            S_SAT:
            begin
                if (item_reg.rate_sum[48])
                begin
                    integ_reg <= (im_reg > POS55_P) ? NEG55 : 56'd0 - im_reg[55:0];
                end
                else
                begin
                    integ_reg <= (im_reg > {8'b0, POS55}) ? POS55 : im_reg[55:0];
                end
            end
            S_RES:
            begin
                sum_reg <= {{8{item_reg.change[48]}}, item_reg.change}
                         + {integ_reg[55], integ_reg};
                ai_reg  <= integ_reg[55] ? 56'd0 - integ_reg : integ_reg;
            end
            S_REF:
            begin
                case (sum_reg[56:55])
                    2'b01:   resid_reg <= POS55;
                    2'b10:   resid_reg <= NEG55;
                    default: resid_reg <= sum_reg[55:0];
                endcase
                ref_reg <= ({7'b0, ac_reg} > ai_reg) ? {7'b0, ac_reg} : ai_reg;
            end
            S_TOL:
            begin
                aresid_reg <= resid_reg[55] ? 56'd0 - resid_reg : resid_reg;
                p1_reg     <= mul_p1;
                p2_reg     <= mul_p2[31:16];
            end
            S_CMP:
            begin
                tol_reg <= (scaled > {8'b0, cfg.abs_tolerance}) ? scaled
                         : {8'b0, cfg.abs_tolerance};
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    m_tlast_reg <= item_reg.last;
                    m_tdata_reg <= {6'b0, sum_res_upd, sum_int_upd, sum_chg_upd, peak_upd,
                                    fail_upd, in_tol, tol_reg[54:0], resid_reg, integ_reg,
                                    item_reg.change, cnt_ext[11:0]};
                end
            end
            default:
            begin
                item_reg <= item_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && item_reg.last) |=> cnt_reg == '0 && fail_reg == '0 && sum_res_reg == '0)
        else $error("totals not cleared after the last region");

    a_valid_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_UPD))
        else $error("result presented outside the update step");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == S_MAG)
        else $error("popped item did not start the sequencer");

    a_peak_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !item_reg.last) |=> peak_reg >= $past(peak_reg))
        else $error("largest residual decreased during an audit");

endmodule

`default_nettype wire

// ----- sv/region_continuity_ledger.sv -----
// Top level of the region continuity ledger: configuration registers and stream wiring.
`default_nettype none

// Each region item passes through the back-end sequencer in one step that takes it from the
// queue and ten arithmetic steps (magnitudes, two partial products, rounding, product sum,
// saturation, residual sum, residual clamp and reference, tolerance scaling, compare, and
// totals update); a new item is taken only once the last one is done. A two-entry queue
// after the input lets up to two items wait, and the result sits in an output register;
// the sequencer stalls only when that register is still full at its final step. Totals
// are cleared after an item marked last.

module region_continuity_ledger #(
    parameter int MAX_REGIONS = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rcl_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [rcl_pkg::PDATA_W-1:0]     pwdata,
    output logic [rcl_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // prev_volume, cur_volume, prev_rate, cur_rate
    input  wire logic [rcl_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // region_number, volume_change, integrated_volume, residual, tolerance,
    // within_tolerance, failed_count, max_abs_residual, total_volume_change,
    // total_integrated, total_residual, zero fill
    output logic [rcl_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast
);

    logic [47:0]         abs_tol_reg;
    logic [15:0]         rel_tol_reg;
    logic [31:0]         step_reg;
    logic                cfg_wr;
    logic [1:0]          cfg_idx;
    rcl_pkg::rcl_cfg_t   cfg;
    logic                q_valid;
    rcl_pkg::rcl_item_t  q_item;
    logic                q_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[rcl_pkg::PADDR_W-1:rcl_pkg::CFG_IDX_LO];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_tol_reg <= 48'd1;
            rel_tol_reg <= '0;
            step_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                rcl_pkg::REG_ABS_TOL: abs_tol_reg <= pwdata[47:0];
                rcl_pkg::REG_REL_TOL: rel_tol_reg <= pwdata[15:0];
                rcl_pkg::REG_STEP:    step_reg    <= pwdata[31:0];
                default:              step_reg    <= step_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            rcl_pkg::REG_ABS_TOL: prdata = {16'b0, abs_tol_reg};
            rcl_pkg::REG_REL_TOL: prdata = {48'b0, rel_tol_reg};
            rcl_pkg::REG_STEP:    prdata = {32'b0, step_reg};
            default:              prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.abs_tolerance = abs_tol_reg;
        cfg.rel_tolerance = rel_tol_reg;
        cfg.step_duration = step_reg;
    end

    rcl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    rcl_back #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
